>>> sv/clcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_pkg: shared types and constants for the character LCD sequencer
// Request and response payloads, decoded operation format, command codes
// and the depth of the request queue.
// ----------------------------------------------------------------------------
package clcd_pkg;

	// Request queue sizing
	localparam int QUEUE_DEPTH = 8;
	localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int QSUM_W      = QCNT_W + 1;

	// Request type codes
	localparam logic [2:0] REQ_TICK    = 3'd0;
	localparam logic [2:0] REQ_START   = 3'd1;
	localparam logic [2:0] REQ_DATA    = 3'd2;
	localparam logic [2:0] REQ_CLEAR   = 3'd3;
	localparam logic [2:0] REQ_CURSOR  = 3'd4;
	localparam logic [2:0] REQ_COMMAND = 3'd5;

	// Configuration register indexes
	localparam logic [2:0] CFG_FOUR_BIT = 3'd0;
	localparam logic [2:0] CFG_FUNCTION = 3'd1;
	localparam logic [2:0] CFG_DISPLAY  = 3'd2;
	localparam logic [2:0] CFG_ENTRY    = 3'd3;
	localparam logic [2:0] CFG_TICK_MS  = 3'd4;

	// LCD command bytes and timing constants
	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_DDRAM_ADDR = 8'h80;
	localparam logic [7:0] ROW1_OFFSET    = 8'h40;
	localparam logic [7:0] PRE_NIBBLE     = 8'h02;
	localparam logic [5:0] POWER_ON_MS    = 6'd30;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] data_byte;
		logic [1:0] cursor_row;
		logic [5:0] cursor_col;
	} req_t;

	typedef struct packed {
		logic [7:0] data_pins;
		logic       reg_select;
		logic       enable_pin;
		logic       initialized;
		logic       accepted;
		logic       queue_busy;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_TICK,
		OP_START,
		OP_PUSH
	} op_kind_t;

	typedef enum logic [1:0] {
		KIND_CMD,
		KIND_DATA,
		KIND_NONE
	} entry_kind_t;

	typedef struct packed {
		entry_kind_t kind;
		logic [7:0]  data;
	} entry_t;

	typedef struct packed {
		op_kind_t op;
		entry_t   entry;
	} op_t;

	typedef enum logic [1:0] {
		PH_OFF,
		PH_INIT,
		PH_OPER
	} phase_t;

	typedef enum logic [2:0] {
		ST_WAIT,
		ST_PRE,
		ST_FSET,
		ST_DCTL,
		ST_CLR,
		ST_ENTRY,
		ST_END
	} init_step_t;

endpackage

>>> sv/clcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_front: request decoder
// Classifies each incoming item as a tick, a start, a queue push or (for an
// unknown type) a no-op, and builds the queue entry (kind, byte) for requests.
// ----------------------------------------------------------------------------
module clcd_front import clcd_pkg::*; (
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic op_valid,
	input  logic op_ready,
	output op_t  op
);

	assign op_valid  = req_valid;
	assign req_ready = op_ready;

	always_comb begin
		op.op         = OP_NOP;
		op.entry.kind = KIND_NONE;
		op.entry.data = 8'h00;
		unique case (req.req_type)
			REQ_TICK: begin
				op.op = OP_TICK;
			end
			REQ_START: begin
				op.op = OP_START;
			end
			REQ_DATA: begin
				op.op         = OP_PUSH;
				op.entry.kind = KIND_DATA;
				op.entry.data = req.data_byte;
			end
			REQ_CLEAR: begin
				op.op         = OP_PUSH;
				op.entry.kind = KIND_CMD;
				op.entry.data = CMD_CLEAR;
			end
			REQ_CURSOR: begin
				op.op = OP_PUSH;
				// Rows beyond the second still occupy a slot but drive nothing.
				if (req.cursor_row == 2'd0) begin
					op.entry.kind = KIND_CMD;
					op.entry.data = CMD_DDRAM_ADDR + {2'b00, req.cursor_col};
				end else if (req.cursor_row == 2'd1) begin
					op.entry.kind = KIND_CMD;
					op.entry.data = CMD_DDRAM_ADDR + ROW1_OFFSET + {2'b00, req.cursor_col};
				end
			end
			REQ_COMMAND: begin
				op.op         = OP_PUSH;
				op.entry.kind = KIND_CMD;
				op.entry.data = req.data_byte;
			end
			default: begin
				op.op = OP_NOP;
			end
		endcase
	end

endmodule

>>> sv/clcd_op_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_op_fifo: two-entry queue of decoded operations
// Decouples the decoder from the sequencer so that either side can stall.
// ----------------------------------------------------------------------------
module clcd_op_fifo import clcd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  op_t  wr_op,
	output logic rd_valid,
	input  logic rd_ready,
	output op_t  rd_op
);

	op_t        slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_op    = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> sv/clcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_back: LCD sequencer
// Holds configuration, the power-on sequence, the request queue and the pin
// levels; handles one operation per cycle into a free response register.
// ----------------------------------------------------------------------------
module clcd_back import clcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       op_valid,
	output logic       op_ready,
	input  op_t        op,
	input  logic       cfg_valid,
	input  logic [2:0] cfg_index,
	input  logic [4:0] cfg_data,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp
);

	typedef struct packed {
		logic [7:0] data;
		logic       rs;
		logic       en;
	} pins_t;

	typedef struct packed {
		pins_t pins;
		logic  nib;
	} latch_res_t;

	// Configuration
	logic       four_bit_q;
	logic [1:0] function_flags_q;
	logic [2:0] display_flags_q;
	logic [1:0] entry_flags_q;
	logic [4:0] tick_ms_q;

	// Sequencer state
	phase_t      phase_q, phase_d;
	init_step_t  step_q, step_d;
	logic [5:0]  wait_q, wait_d;
	logic [2:0]  latch_cnt_q, latch_cnt_d;
	logic        nib_q, nib_d;
	pins_t       pins_q, pins_d;
	logic [QIDX_W-1:0] head_q, head_d;
	logic [QCNT_W-1:0] count_q, count_d;
	entry_t      store_q [QUEUE_DEPTH];

	logic        rsp_valid_q;
	rsp_t        rsp_q, rsp_d;

	logic        step_en;
	logic        acc;
	logic        do_push;
	logic [2:0]  target;
	logic [2:0]  latch_inc;
	logic [5:0]  wait_sum;
	logic [7:0]  init_byte;
	init_step_t  init_next;
	entry_t      head_entry;
	latch_res_t  lr;
	logic [QSUM_W-1:0] tail_sum;
	logic [QIDX_W-1:0] tail_idx;

	function automatic latch_res_t latch_f(pins_t cur, logic nib, logic four,
	                                       logic [7:0] b, logic rs);
		latch_res_t r;
		r.pins    = cur;
		r.nib     = nib;
		r.pins.rs = rs;
		if (!cur.en) begin
			r.pins.data = four ? {4'h0, (nib ? b[7:4] : b[3:0])} : b;
			r.pins.en   = 1'b1;
		end else begin
			r.pins.en = 1'b0;
			if (four) begin
				r.nib = ~nib;
			end
		end
		return r;
	endfunction

	assign step_en   = op_valid && (!rsp_valid_q || rsp_ready);
	assign op_ready  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign target     = four_bit_q ? 3'd4 : 3'd2;
	assign latch_inc  = latch_cnt_q + 3'd1;
	assign wait_sum   = wait_q + {1'b0, tick_ms_q};
	assign head_entry = store_q[head_q];

	always_comb begin
		tail_sum = QSUM_W'(head_q) + QSUM_W'(count_q);
		if (tail_sum >= QSUM_W'(QUEUE_DEPTH)) begin
			tail_sum = tail_sum - QSUM_W'(QUEUE_DEPTH);
		end
		tail_idx = tail_sum[QIDX_W-1:0];
	end

	// Byte and follow-on step for each command of the power-on sequence
	always_comb begin
		unique case (step_q)
			ST_FSET: begin
				init_byte = {2'b00, 1'b1, ~four_bit_q, function_flags_q, 2'b00};
				init_next = ST_DCTL;
			end
			ST_DCTL: begin
				init_byte = {5'b00001, display_flags_q};
				init_next = ST_CLR;
			end
			ST_CLR: begin
				init_byte = CMD_CLEAR;
				init_next = ST_ENTRY;
			end
			ST_ENTRY: begin
				init_byte = {6'b000001, entry_flags_q};
				init_next = ST_END;
			end
			default: begin
				init_byte = 8'h00;
				init_next = ST_END;
			end
		endcase
	end

	// Next state
	always_comb begin
		phase_d     = phase_q;
		step_d      = step_q;
		wait_d      = wait_q;
		latch_cnt_d = latch_cnt_q;
		nib_d       = nib_q;
		pins_d      = pins_q;
		head_d      = head_q;
		count_d     = count_q;
		acc         = 1'b0;
		do_push     = 1'b0;
		lr          = '0;
		if (step_en) begin
			unique case (op.op)
				OP_TICK: begin
					if (phase_q == PH_INIT) begin
						unique case (step_q)
							ST_WAIT: begin
								if (wait_sum >= POWER_ON_MS) begin
									wait_d = 6'd0;
									step_d = four_bit_q ? ST_PRE : ST_FSET;
								end else begin
									wait_d = wait_sum;
								end
							end
							ST_PRE: begin
								// A lone nibble: raise enable once, then lower it.
								if (latch_inc == 3'd1) begin
									latch_cnt_d = latch_inc;
									pins_d.data = PRE_NIBBLE;
									pins_d.en   = 1'b1;
								end else begin
									latch_cnt_d = 3'd0;
									pins_d.en   = 1'b0;
									step_d      = ST_FSET;
								end
							end
							ST_FSET, ST_DCTL, ST_CLR, ST_ENTRY: begin
								latch_cnt_d = latch_inc;
								if (latch_inc >= target) begin
									latch_cnt_d = 3'd0;
									step_d      = init_next;
								end
								lr     = latch_f(pins_q, nib_q, four_bit_q, init_byte, 1'b0);
								pins_d = lr.pins;
								nib_d  = lr.nib;
							end
							default: begin
								step_d  = ST_END;
								phase_d = PH_OPER;
							end
						endcase
					end else if (phase_q == PH_OPER && count_q != '0) begin
						if (latch_cnt_q >= target) begin
							// Completion tick: retire the head request.
							latch_cnt_d = 3'd0;
							head_d      = (head_q == QIDX_W'(QUEUE_DEPTH - 1)) ?
							              '0 : head_q + QIDX_W'(1);
							count_d     = count_q - QCNT_W'(1);
						end else begin
							if (head_entry.kind == KIND_DATA || head_entry.kind == KIND_CMD) begin
								lr     = latch_f(pins_q, nib_q, four_bit_q, head_entry.data,
								                 head_entry.kind == KIND_DATA);
								pins_d = lr.pins;
								nib_d  = lr.nib;
							end
							latch_cnt_d = latch_inc;
						end
					end
				end
				OP_START: begin
					if (phase_q == PH_OFF) begin
						phase_d = PH_INIT;
					end
				end
				OP_PUSH: begin
					if (count_q < QCNT_W'(QUEUE_DEPTH)) begin
						do_push = 1'b1;
						acc     = 1'b1;
						count_d = count_q + QCNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Response built from the state after the item
	always_comb begin
		rsp_d.data_pins   = pins_d.data;
		rsp_d.reg_select  = pins_d.rs;
		rsp_d.enable_pin  = pins_d.en;
		rsp_d.initialized = (phase_d == PH_OPER);
		rsp_d.accepted    = acc;
		rsp_d.queue_busy  = (count_d != '0);
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[tail_idx] <= op.entry;
		end
		if (step_en) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_bit_q       <= 1'b1;
			function_flags_q <= 2'd2;
			display_flags_q  <= 3'd4;
			entry_flags_q    <= 2'd2;
			tick_ms_q        <= 5'd2;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FOUR_BIT: four_bit_q       <= cfg_data[0];
				CFG_FUNCTION: function_flags_q <= cfg_data[1:0];
				CFG_DISPLAY:  display_flags_q  <= cfg_data[2:0];
				CFG_ENTRY:    entry_flags_q    <= cfg_data[1:0];
				CFG_TICK_MS:  tick_ms_q        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OFF;
			step_q      <= ST_WAIT;
			wait_q      <= 6'd0;
			latch_cnt_q <= 3'd0;
			nib_q       <= 1'b1;
			pins_q      <= '0;
			head_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			step_q      <= step_d;
			wait_q      <= wait_d;
			latch_cnt_q <= latch_cnt_d;
			nib_q       <= nib_d;
			pins_q      <= pins_d;
			head_q      <= head_d;
			count_q     <= count_d;
			if (step_en) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("request queue count exceeds its depth");

	a_oper_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_OPER |-> step_q == ST_END)
		else $error("operating phase entered before the init sequence ended");

	a_no_return_off: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_OFF |=> phase_q != PH_OFF)
		else $error("phase fell back to off without a reset");

	a_latch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		latch_cnt_q <= 3'd4)
		else $error("latch count beyond the longest send");
`endif

endmodule

>>> sv/char_lcd_request_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_request_sequencer_unit: character LCD request sequencer
// Drives HD44780-style pin levels from tick, start and request items.
// ----------------------------------------------------------------------------
// Usage
//   req     : one item per transfer (tick, start, data byte, clear, set
//             cursor, command). Every item produces exactly one response.
//   rsp     : pin levels, initialized flag, queue acceptance and busy flag
//             as they stand after the item has been handled.
//   cfg     : register writes (bus mode, flags, tick period), always ready;
//             write only while no item is in flight.
// Throughput is one item per clock cycle while responses are taken. A request
// is written into the two-entry operation queue at its transfer, and the
// sequencer later takes it from there into the response register, behind any
// earlier items still queued. The sequencer handles one operation per cycle,
// while its response register is free, with a single update of its state
// registers and request queue.
// If the receiver stalls, the response register holds and the operation
// queue fills; req_ready falls once both queue entries are taken.
// Reset clears the phase to off, the request queue to empty, the pins to
// zero and the configuration to its defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module char_lcd_request_sequencer_unit import clcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [4:0] cfg_data
);

	logic dec_valid;
	logic dec_ready;
	op_t  dec_op;
	logic seq_valid;
	logic seq_ready;
	op_t  seq_op;

	assign cfg_ready = 1'b1;

	clcd_front u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.op_valid  (dec_valid),
		.op_ready  (dec_ready),
		.op        (dec_op)
	);

	clcd_op_fifo u_op_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (dec_valid),
		.wr_ready (dec_ready),
		.wr_op    (dec_op),
		.rd_valid (seq_valid),
		.rd_ready (seq_ready),
		.rd_op    (seq_op)
	);

	clcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (seq_valid),
		.op_ready  (seq_ready),
		.op        (seq_op),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
